// ===== design/tka_pkg.sv =====
// ----------------------------------------------------------------------------
// tka_pkg
// Shared widths, types and request codes of the top-k target assigner.
// ----------------------------------------------------------------------------
package tka_pkg;

    localparam int SLOTS       = 64;
    localparam int ROBOTS      = 64;
    localparam int RADIUS_BITS = 16;
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int ROBOT_W     = 7;
    localparam int PID_W       = 12;

    typedef logic [RADIUS_BITS-1:0] radius_t;
    typedef logic [PID_W-1:0]       pid_t;
    typedef logic [ROBOT_W-1:0]     robot_t;
    typedef logic [CNT_W-1:0]       cnt_t;

    typedef enum logic [1:0] {
        REQ_ROBOT    = 2'd0,
        REQ_PARTICLE = 2'd1,
        REQ_FINISH   = 2'd2
    } req_t;

    typedef struct packed {
        logic ins_en;
        logic shift;
    } cell_cmd_t;

endpackage

// ===== design/tka_cell.sv =====
// ----------------------------------------------------------------------------
// tka_cell
// One slot of the sorted chain: a kept particle and one free robot id.
// ----------------------------------------------------------------------------
module tka_cell (
    input  logic                clk,
    input  tka_pkg::cell_cmd_t  cmd,
    input  logic                valid,
    input  tka_pkg::radius_t    new_radius,
    input  tka_pkg::pid_t       new_pid,
    input  logic                prev_ins,
    input  tka_pkg::radius_t    prev_radius,
    input  tka_pkg::pid_t       prev_pid,
    input  logic                rob_wr,
    input  tka_pkg::robot_t     new_robot,
    input  tka_pkg::radius_t    next_radius,
    input  tka_pkg::pid_t       next_pid,
    input  tka_pkg::robot_t     next_robot,
    output logic                ins,
    output tka_pkg::radius_t    radius,
    output tka_pkg::pid_t       pid,
    output tka_pkg::robot_t     robot
);
    import tka_pkg::*;

    radius_t radius_reg, radius_next;
    pid_t    pid_reg, pid_next;
    robot_t  robot_reg, robot_next;

    // The new particle belongs at or before this slot.
    assign ins = !valid || (new_radius > radius_reg);

    always_comb
    begin
        radius_next = radius_reg;
        pid_next    = pid_reg;
        robot_next  = robot_reg;
        if (cmd.shift)
        begin
            radius_next = next_radius;
            pid_next    = next_pid;
            robot_next  = next_robot;
        end
        else
        begin
            if (cmd.ins_en && ins)
            begin
                radius_next = prev_ins ? prev_radius : new_radius;
                pid_next    = prev_ins ? prev_pid : new_pid;
            end
            if (rob_wr)
            begin
                robot_next = new_robot;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        radius_reg <= radius_next;
        pid_reg    <= pid_next;
        robot_reg  <= robot_next;
    end

    assign radius = radius_reg;
    assign pid    = pid_reg;
    assign robot  = robot_reg;

endmodule

// ===== design/top_k_target_assigner.sv =====
// ----------------------------------------------------------------------------
// top_k_target_assigner
// Keeps the largest particles in a sorted chain and pairs them with free robots.
// ----------------------------------------------------------------------------
// Status and particle beats are taken one per cycle while idle.
// A finish beat yields its first result in the next cycle, then one per cycle
// while m_tready is high: max(1, number of pairs) beats, with no input taken.
// Reset clears both counts and the state machine; no clearing pass is needed.
// ----------------------------------------------------------------------------
module top_k_target_assigner (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // robot_id[6:0], robot_busy[7], particle_id[19:8], radius[35:20]
    input  logic [39:0] s_tdata,
    // req_type[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // robot_id_out[6:0], particle_id_out[18:7]
    output logic [23:0] m_tdata,
    // has_pair[0]
    output logic        m_tuser,
    output logic        m_tlast
);
    import tka_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_NONE
    } state_t;

    state_t state_reg, state_next;
    cnt_t   count_reg, count_next;
    cnt_t   kept_reg, kept_next;
    cnt_t   rem_reg, rem_next;

    logic      s_beat, m_beat;
    logic      accept;
    radius_t   in_radius;
    pid_t      in_pid;
    robot_t    in_robot;
    logic      in_busy;
    cell_cmd_t cmd;

    logic    [SLOTS-1:0] ins_vec;
    logic    [SLOTS-1:0] k_mask;
    radius_t             rad_arr   [SLOTS];
    pid_t                pid_arr   [SLOTS];
    robot_t              robot_arr [SLOTS];

    assign in_robot  = s_tdata[6:0];
    assign in_busy   = s_tdata[7];
    assign in_pid    = s_tdata[19:8];
    assign in_radius = s_tdata[35:20];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_beat   = s_tvalid && s_tready;
    assign m_tvalid = (state_reg != ST_IDLE);
    assign m_beat   = m_tvalid && m_tready;

    assign accept     = |(ins_vec & k_mask);
    assign cmd.ins_en = s_beat && (s_tuser == REQ_PARTICLE) && accept;
    assign cmd.shift  = m_beat && (state_reg == ST_EMIT);

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_chain
        logic    prev_ins_w;
        radius_t prev_rad_w, next_rad_w;
        pid_t    prev_pid_w, next_pid_w;
        robot_t  next_robot_w;
        logic    rob_wr_w;

        assign k_mask[i] = (CNT_W'(i) < count_reg);
        assign rob_wr_w  = s_beat && (s_tuser == REQ_ROBOT) && !in_busy
                           && (count_reg < CNT_W'(ROBOTS)) && (count_reg == CNT_W'(i));

        if (i == 0)
        begin : g_first
            assign prev_ins_w = 1'b0;
            assign prev_rad_w = '0;
            assign prev_pid_w = '0;
        end
        else
        begin : g_mid
            assign prev_ins_w = ins_vec[i-1];
            assign prev_rad_w = rad_arr[i-1];
            assign prev_pid_w = pid_arr[i-1];
        end

        if (i == SLOTS - 1)
        begin : g_last
            assign next_rad_w   = '0;
            assign next_pid_w   = '0;
            assign next_robot_w = '0;
        end
        else
        begin : g_body
            assign next_rad_w   = rad_arr[i+1];
            assign next_pid_w   = pid_arr[i+1];
            assign next_robot_w = robot_arr[i+1];
        end

        tka_cell u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .valid       (CNT_W'(i) < kept_reg),
            .new_radius  (in_radius),
            .new_pid     (in_pid),
            .prev_ins    (prev_ins_w),
            .prev_radius (prev_rad_w),
            .prev_pid    (prev_pid_w),
            .rob_wr      (rob_wr_w),
            .new_robot   (in_robot),
            .next_radius (next_rad_w),
            .next_pid    (next_pid_w),
            .next_robot  (next_robot_w),
            .ins         (ins_vec[i]),
            .radius      (rad_arr[i]),
            .pid         (pid_arr[i]),
            .robot       (robot_arr[i])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        kept_next  = kept_reg;
        rem_next   = rem_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_beat)
                begin
                    case (s_tuser)
                        REQ_ROBOT:
                        begin
                            if (!in_busy && (count_reg < CNT_W'(ROBOTS)))
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        REQ_PARTICLE:
                        begin
                            if (accept && (kept_reg < count_reg))
                            begin
                                kept_next = kept_reg + 1'b1;
                            end
                        end
                        REQ_FINISH:
                        begin
                            rem_next   = kept_reg;
                            state_next = (kept_reg == '0) ? ST_NONE : ST_EMIT;
                            count_next = '0;
                            kept_next  = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_EMIT:
            begin
                if (m_beat)
                begin
                    rem_next = rem_reg - 1'b1;
                    if (rem_reg == CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_NONE:
            begin
                if (m_beat)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            kept_reg  <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            kept_reg  <= kept_next;
            rem_reg   <= rem_next;
        end
    end

    always_comb
    begin
        m_tdata = '0;
        m_tuser = 1'b0;
        m_tlast = 1'b0;
        if (state_reg == ST_EMIT)
        begin
            m_tdata[6:0]  = robot_arr[0];
            m_tdata[18:7] = pid_arr[0];
            m_tuser       = 1'b1;
            m_tlast       = (rem_reg == CNT_W'(1));
        end
        else if (state_reg == ST_NONE)
        begin
            m_tlast = 1'b1;
        end
    end

    a_kept_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        kept_reg <= count_reg)
        else $error("kept count exceeds free robot count");

    a_emit_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (rem_reg != '0))
        else $error("emit run with no pairs left");

    a_nopair_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> m_tlast)
        else $error("no-pair beat without last");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_beat && m_tlast) |=> (state_reg == ST_IDLE) && (count_reg == '0))
        else $error("finish run did not return to idle");

endmodule

// ===== sim/tb_top_k_target_assigner.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top_k_target_assigner
// Sends robot status, particle, finish and unknown beats, mostly with random gaps
// on both sides. A behavioral copy of the ranking logic predicts every pair.
// ----------------------------------------------------------------------------
module tb_top_k_target_assigner;
    import tka_pkg::*;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int         IDLE_PCT    = 20;
    localparam int         RUN_BEATS   = 40;

    typedef struct packed {
        robot_t robot;
        pid_t   pid;
        logic   has_pair;
        logic   last;
    } pairing_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    robot_t   free_ids [ROBOTS];
    int       free_cnt = 0;
    radius_t  kept_radius [SLOTS];
    pid_t     kept_pid [SLOTS];
    int       kept_cnt = 0;
    pairing_t pairing_q [$];
    int       errors   = 0;
    bit       no_gaps  = 1'b0;

    top_k_target_assigner i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // A particle goes behind every kept entry whose radius is at least its own.
    function automatic void rank_particle(radius_t radius, pid_t pid);
        int k;
        int pos;
        int j;
        k   = free_cnt;
        pos = 0;
        if (k == 0)
            return;
        if (kept_cnt >= k && radius <= kept_radius[k-1])
            return;
        while (pos < kept_cnt && kept_radius[pos] >= radius)
            pos++;
        if (pos >= k)
            return;
        j = (kept_cnt < k) ? kept_cnt : k - 1;
        while (j > pos)
        begin
            kept_radius[j] = kept_radius[j-1];
            kept_pid[j]    = kept_pid[j-1];
            j--;
        end
        kept_radius[pos] = radius;
        kept_pid[pos]    = pid;
        if (kept_cnt < k)
            kept_cnt++;
    endfunction

    function automatic void assign_targets();
        pairing_t res;
        int       n;
        if (kept_cnt == 0)
        begin
            res = '{robot: '0, pid: '0, has_pair: 1'b0, last: 1'b1};
            pairing_q.push_back(res);
        end
        else
        begin
            n = (kept_cnt < free_cnt) ? kept_cnt : free_cnt;
            for (int i = 0; i < n; i++)
            begin
                res = '{robot: free_ids[i], pid: kept_pid[i], has_pair: 1'b1,
                        last: (i == n - 1)};
                pairing_q.push_back(res);
            end
        end
        free_cnt = 0;
        kept_cnt = 0;
    endfunction

    function automatic void predict_beat(logic [1:0] req, robot_t robot, logic busy,
                                         pid_t pid, radius_t radius);
        if (req == REQ_ROBOT)
        begin
            if (!busy && free_cnt < ROBOTS)
            begin
                free_ids[free_cnt] = robot;
                free_cnt++;
            end
        end
        else if (req == REQ_PARTICLE)
            rank_particle(radius, pid);
        else if (req == REQ_FINISH)
            assign_targets();
    endfunction

    function automatic robot_t random_robot();
        if ($urandom_range(0, 7) == 0)
            return robot_t'($urandom_range(0, 127));
        return robot_t'($urandom_range(1, ROBOTS));
    endfunction

    // Half of the radii come from a few coarse values so that ties are common.
    function automatic radius_t random_radius();
        if ($urandom_range(0, 1) == 0)
            return radius_t'($urandom_range(0, 7) << 8);
        return radius_t'($urandom_range(0, 65535));
    endfunction

    task automatic send_beat(input logic [1:0] req, input robot_t robot, input logic busy,
                             input pid_t pid, input radius_t radius);
        while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {4'b0, radius, pid, busy, robot};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_beat(req, robot, busy, pid, radius);
    endtask

    task automatic send_robot(input robot_t robot, input logic busy);
        send_beat(REQ_ROBOT, robot, busy, '0, '0);
    endtask

    task automatic send_particle(input pid_t pid, input radius_t radius);
        send_beat(REQ_PARTICLE, '0, 1'b0, pid, radius);
    endtask

    task automatic send_finish();
        send_beat(REQ_FINISH, '0, 1'b0, '0, '0);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pairing_q.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic test_empty_finish();
        send_finish();
        send_robot(7'd3, 1'b1);
        send_particle(12'd5, 16'h1234);
        send_beat(REQ_UNKNOWN, 7'd127, 1'b0, 12'hFFF, 16'hFFFF);
        send_finish();
        send_robot(7'd5, 1'b0);
        send_finish();
    endtask

    task automatic test_ranking();
        send_robot(7'd127, 1'b0);
        send_robot(7'd64, 1'b1);
        send_robot(7'd0, 1'b0);
        send_robot(7'd1, 1'b0);
        send_particle(12'd4095, 16'hFFFF);
        send_particle(12'd1, 16'h0100);
        send_particle(12'd2, 16'h0100);
        send_particle(12'd0, 16'h0000);
        send_particle(12'd3, 16'h0100);
        send_robot(7'd64, 1'b0);
        send_particle(12'd7, 16'h0080);
        send_particle(12'd8, 16'h0080);
        send_beat(REQ_UNKNOWN, 7'd0, 1'b1, 12'd0, 16'h0000);
        send_particle(12'd9, 16'h0200);
        send_finish();
        send_robot(7'd2, 1'b0);
        send_robot(7'd3, 1'b0);
        send_particle(12'd11, 16'h00FF);
        send_finish();
    endtask

    // Both lists filled to the top, with the surplus robots left out.
    task automatic test_full_lists();
        no_gaps = 1'b1;
        for (int i = 0; i < ROBOTS + 2; i++)
            send_robot(random_robot(), 1'b0);
        for (int i = 0; i < SLOTS + 6; i++)
            send_particle(pid_t'($urandom_range(0, 4095)), random_radius());
        send_finish();
        wait_drained();
        no_gaps = 1'b0;
    endtask

    task automatic test_random_runs();
        int sent;
        int n_rob;
        int n_part;
        sent = 0;
        while (sent < RUN_BEATS)
        begin
            n_rob = ($urandom_range(0, 9) == 0) ? $urandom_range(0, ROBOTS)
                                                : $urandom_range(1, 6);
            if ($urandom_range(0, 7) == 0)
                n_rob = 0;
            for (int i = 0; i < n_rob; i++)
                send_robot(random_robot(), $urandom_range(0, 3) == 0);
            n_part = $urandom_range(0, 12);
            for (int i = 0; i < n_part; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_robot(random_robot(), $urandom_range(0, 3) == 0);
                if ($urandom_range(0, 19) == 0)
                    send_beat(REQ_UNKNOWN, random_robot(), $urandom_range(0, 1) == 1,
                              pid_t'($urandom_range(0, 4095)), random_radius());
                send_particle(pid_t'($urandom_range(0, 4095)), random_radius());
            end
            send_finish();
            sent += n_rob + n_part + 1;
            if ($urandom_range(0, 4) == 0)
                wait_drained();
        end
    endtask

    always @(posedge clk)
        m_tready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);

    always @(posedge clk)
    begin : check_results
        pairing_t want;
        pairing_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{robot: m_tdata[6:0], pid: m_tdata[18:7], has_pair: m_tuser,
                    last: m_tlast};
            if (pairing_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat robot=%0d particle=%0d pair=%0b last=%0b",
                         $time, got.robot, got.pid, got.has_pair, got.last);
            end
            else
            begin
                want = pairing_q.pop_front();
                if (got !== want)
                begin
                    errors++;
                    $display("%0t: expected robot=%0d particle=%0d pair=%0b last=%0b, %s",
                             $time, want.robot, want.pid, want.has_pair, want.last,
                             "got");
                    $display("%0t:      got robot=%0d particle=%0d pair=%0b last=%0b",
                             $time, got.robot, got.pid, got.has_pair, got.last);
                end
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_finish();
        test_ranking();
        test_full_lists();
        test_random_runs();
        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("[top_k_target_assigner] OK");
        else
            $display("[top_k_target_assigner] ERROR");
        $finish;
    end

    initial
    begin
        #400000;
        $display("[top_k_target_assigner] ERROR");
        $finish;
    end

endmodule
